@@ hdl/spc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg: shared definitions for scan point clustering
// Default sizes, register indexes, reset values and controller states.
// ----------------------------------------------------------------------------
package spc_pkg;

   localparam int SPC_COUNT_LIMIT = 4095;
   localparam int SPC_COORD_BITS  = 16;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int POINTS_BITS    = 12;
   localparam int RADIUS_BITS    = 16;

   localparam logic [15:0]           BREAK_RESET      = 16'd100;
   localparam logic [POINTS_BITS-1:0] MIN_POINTS_RESET = 12'd2;
   localparam logic [POINTS_BITS-1:0] MAX_POINTS_RESET = 12'd100;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_BREAK      = 2'd0,
      REG_MIN_POINTS = 2'd1,
      REG_MAX_POINTS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TEST,
      S_JOIN,
      S_OPEN,
      S_CLOSE,
      S_RDIST,
      S_CALC,
      S_EMIT
   } state_type;

endpackage

@@ hdl/spc_sqdist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_sqdist: bit-serial squared distance
// Squares |ax-bx| and |ay-by| by shift and add, one multiplier bit per
// cycle in two lanes, and sums the two squares.
// ----------------------------------------------------------------------------
module spc_sqdist #(
   parameter int COORD_BITS = spc_pkg::SPC_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [COORD_BITS-1:0]  ax,
   input  logic signed [COORD_BITS-1:0]  ay,
   input  logic signed [COORD_BITS-1:0]  bx,
   input  logic signed [COORD_BITS-1:0]  by,
   output logic                          busy,
   output logic [2*COORD_BITS:0]         d2
);
   import spc_pkg::*;

   localparam int PROD_BITS = 2 * COORD_BITS;
   localparam int STEP_BITS = $clog2(COORD_BITS);

   logic signed [COORD_BITS:0] diff [2];
   logic [COORD_BITS-1:0]      mag  [2];

   logic [PROD_BITS-1:0]  mcand_ff  [2], mcand_in  [2];
   logic [PROD_BITS-1:0]  acc_ff    [2], acc_in    [2];
   logic [COORD_BITS-1:0] mplier_ff [2], mplier_in [2];
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;

   always_comb begin
      diff[0] = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
      diff[1] = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
      for (int i = 0; i < 2; i++) begin
         mag[i] = diff[i][COORD_BITS] ? COORD_BITS'(-diff[i]) : diff[i][COORD_BITS-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      for (int i = 0; i < 2; i++) begin
         mcand_in[i]  = mcand_ff[i];
         acc_in[i]    = acc_ff[i];
         mplier_in[i] = mplier_ff[i];
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         for (int i = 0; i < 2; i++) begin
            mcand_in[i]  = PROD_BITS'(mag[i]);
            acc_in[i]    = '0;
            mplier_in[i] = mag[i];
         end
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            if (mplier_ff[i][0]) begin
               acc_in[i] = acc_ff[i] + mcand_ff[i];
            end
            mcand_in[i]  = mcand_ff[i] << 1;
            mplier_in[i] = mplier_ff[i] >> 1;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(COORD_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      for (int i = 0; i < 2; i++) begin
         mcand_ff[i]  <= mcand_in[i];
         acc_ff[i]    <= acc_in[i];
         mplier_ff[i] <= mplier_in[i];
      end
   end

   assign busy = busy_ff;
   assign d2   = {1'b0, acc_ff[0]} + {1'b0, acc_ff[1]};

endmodule

@@ hdl/spc_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_divider: two-lane restoring divider
// Divides the signed x and y sums by the point count, one quotient bit per
// cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module spc_divider #(
   parameter int COORD_BITS = spc_pkg::SPC_COORD_BITS,
   parameter int CNT_BITS   = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [COORD_BITS+CNT_BITS-1:0] sum_x,
   input  logic signed [COORD_BITS+CNT_BITS-1:0] sum_y,
   input  logic [CNT_BITS-1:0]                   divisor,
   output logic                                  busy,
   output logic signed [COORD_BITS-1:0]          quo_x,
   output logic signed [COORD_BITS-1:0]          quo_y
);
   import spc_pkg::*;

   localparam int SUM_BITS  = COORD_BITS + CNT_BITS;
   localparam int STEP_BITS = $clog2(SUM_BITS);

   logic signed [SUM_BITS-1:0] sum_sel [2];
   logic [CNT_BITS:0]          trial   [2];
   logic [SUM_BITS-1:0]        signed_q [2];

   logic [SUM_BITS-1:0]  quo_ff [2], quo_in [2];
   logic [CNT_BITS-1:0]  rem_ff [2], rem_in [2];
   logic                 neg_ff [2], neg_in [2];
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;

   always_comb begin
      sum_sel[0] = sum_x;
      sum_sel[1] = sum_y;
      busy_in = busy_ff;
      step_in = step_ff;
      for (int i = 0; i < 2; i++) begin
         quo_in[i] = quo_ff[i];
         rem_in[i] = rem_ff[i];
         neg_in[i] = neg_ff[i];
         trial[i]  = {rem_ff[i], quo_ff[i][SUM_BITS-1]};
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         for (int i = 0; i < 2; i++) begin
            neg_in[i] = sum_sel[i][SUM_BITS-1];
            quo_in[i] = sum_sel[i][SUM_BITS-1] ? SUM_BITS'(-sum_sel[i]) : sum_sel[i];
            rem_in[i] = '0;
         end
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            if (trial[i] >= {1'b0, divisor}) begin
               rem_in[i] = CNT_BITS'(trial[i] - {1'b0, divisor});
               quo_in[i] = {quo_ff[i][SUM_BITS-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[i][CNT_BITS-1:0];
               quo_in[i] = {quo_ff[i][SUM_BITS-2:0], 1'b0};
            end
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      for (int i = 0; i < 2; i++) begin
         quo_ff[i] <= quo_in[i];
         rem_ff[i] <= rem_in[i];
         neg_ff[i] <= neg_in[i];
      end
   end

   // restore the sign of the dividend
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         signed_q[i] = neg_ff[i] ? SUM_BITS'(-quo_ff[i]) : quo_ff[i];
      end
   end

   assign busy  = busy_ff;
   assign quo_x = signed_q[0][COORD_BITS-1:0];
   assign quo_y = signed_q[1][COORD_BITS-1:0];

endmodule

@@ hdl/spc_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_isqrt: digit-serial integer square root
// Brings down two radicand bits per cycle and settles one root bit,
// giving the floor of the square root.
// ----------------------------------------------------------------------------
module spc_isqrt #(
   parameter int COORD_BITS = spc_pkg::SPC_COORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2*COORD_BITS:0]  value,
   output logic                   busy,
   output logic [COORD_BITS:0]    root
);
   import spc_pkg::*;

   localparam int RAD_BITS  = 2 * COORD_BITS + 2;
   localparam int ROOT_BITS = COORD_BITS + 1;
   localparam int REM_BITS  = COORD_BITS + 4;
   localparam int STEP_BITS = $clog2(ROOT_BITS);

   logic [REM_BITS-1:0]  rem_sh, trial;

   logic [RAD_BITS-1:0]  src_ff, src_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;

   always_comb begin
      rem_sh  = {rem_ff[REM_BITS-3:0], src_ff[RAD_BITS-1 -: 2]};
      trial   = REM_BITS'({root_ff, 2'b01});
      busy_in = busy_ff;
      step_in = step_ff;
      src_in  = src_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         src_in  = {1'b0, value};
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         src_in = src_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

@@ hdl/scan_point_clustering.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_point_clustering: breakpoint segmentation of lidar scan points
// Groups successive points closer than the break distance and reports the
// centroid, half-span radius and size of each cluster of acceptable size.
// ----------------------------------------------------------------------------
// Flow: a point tested against the open cluster passes the distance unit, then joins
//   it or closes it; the first point of a scan opens a cluster with no distance test.
//   Each reported cluster then runs the distance, divider and root units and waits
//   for a free output slot.
// Throughput: one request in work at a time; a result waits in the output register.
// Reset: synchronous; clears control state and restores the register defaults.
module scan_point_clustering #(
   parameter int COUNT_LIMIT = spc_pkg::SPC_COUNT_LIMIT,
   parameter int COORD_BITS  = spc_pkg::SPC_COORD_BITS
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // req_tdata: point_x, point_y (zero padded to bytes)
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]            req_tdata,
   input  logic                                         req_tlast,
   // rsp_tdata: centre_x, centre_y, radius_mm, point_count (zero padded)
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   output logic [((2*COORD_BITS+28+7)/8)*8-1:0]         rsp_tdata,
   output logic                                         rsp_tlast,
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [spc_pkg::CSR_INDEX_BITS-1:0]           csr_index,
   input  logic [spc_pkg::CSR_DATA_BITS-1:0]            csr_data
);
   import spc_pkg::*;

   localparam int CNT_BITS  = $clog2(COUNT_LIMIT + 1);
   localparam int SUM_BITS  = COORD_BITS + CNT_BITS;
   localparam int D2_BITS   = 2 * COORD_BITS + 1;
   localparam int CMP_BITS  = (D2_BITS > 32) ? D2_BITS : 32;
   localparam int PCMP_BITS = (CNT_BITS > POINTS_BITS) ? CNT_BITS : POINTS_BITS;
   localparam int OUT_W     = ((2*COORD_BITS+28+7)/8)*8;

   state_type state_ff, state_in;

   logic                         open_ff, open_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic                         eos_ff, eos_in;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [COORD_BITS-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [SUM_BITS-1:0]   sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic                         brk_ff, brk_in;

   logic [15:0]                  break_ff;
   logic [POINTS_BITS-1:0]       min_ff, max_ff;
   logic [31:0]                  thr_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_cx_ff, rsp_cx_in, rsp_cy_ff, rsp_cy_in;
   logic [RADIUS_BITS-1:0]       rsp_rad_ff, rsp_rad_in;
   logic [POINTS_BITS-1:0]       rsp_cnt_ff, rsp_cnt_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         req_fire, slot_free;
   logic                         qualify, eos_reports;
   logic                         dist_start, dist_busy;
   logic                         calc_start, div_busy, sqrt_busy;
   logic signed [COORD_BITS-1:0] dist_ax, dist_ay;
   logic [D2_BITS-1:0]           d2;
   logic signed [COORD_BITS-1:0] quo_x, quo_y;
   logic [COORD_BITS:0]          root, half;
   logic signed [COORD_BITS-1:0] req_x, req_y;

   assign req_x      = req_tdata[COORD_BITS-1:0];
   assign req_y      = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign qualify = (PCMP_BITS'(count_ff) > PCMP_BITS'(min_ff))
                 && (PCMP_BITS'(count_ff) < PCMP_BITS'(max_ff));
   // a freshly opened single-point cluster reports on end of scan only if 0 < 1 < max
   assign eos_reports = eos_ff && (min_ff == '0) && (max_ff > POINTS_BITS'(1));

   assign dist_ax = (state_ff == S_IDLE) ? req_x : first_x_ff;
   assign dist_ay = (state_ff == S_IDLE) ? req_y : first_y_ff;
   assign half    = root >> 1;

   spc_sqdist #(
      .COORD_BITS (COORD_BITS)
   ) u_sqdist (
      .clock (clock),
      .reset (reset),
      .start (dist_start),
      .ax    (dist_ax),
      .ay    (dist_ay),
      .bx    (prev_x_ff),
      .by    (prev_y_ff),
      .busy  (dist_busy),
      .d2    (d2)
   );

   spc_divider #(
      .COORD_BITS (COORD_BITS),
      .CNT_BITS   (CNT_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (calc_start),
      .sum_x   (sum_x_ff),
      .sum_y   (sum_y_ff),
      .divisor (count_ff),
      .busy    (div_busy),
      .quo_x   (quo_x),
      .quo_y   (quo_y)
   );

   spc_isqrt #(
      .COORD_BITS (COORD_BITS)
   ) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (calc_start),
      .value (d2),
      .busy  (sqrt_busy),
      .root  (root)
   );

   // configuration registers; the squared break threshold follows break_ff in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         break_ff <= BREAK_RESET;
         min_ff   <= MIN_POINTS_RESET;
         max_ff   <= MAX_POINTS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BREAK:      break_ff <= csr_data;
            REG_MIN_POINTS: min_ff   <= csr_data[POINTS_BITS-1:0];
            REG_MAX_POINTS: max_ff   <= csr_data[POINTS_BITS-1:0];
            default: ;
         endcase
      end
      thr_ff <= break_ff * break_ff;
   end

   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      eos_in       = eos_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      count_in     = count_ff;
      brk_in       = brk_ff;
      rsp_cx_in    = rsp_cx_ff;
      rsp_cy_in    = rsp_cy_ff;
      rsp_rad_in   = rsp_rad_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      dist_start   = 1'b0;
      calc_start   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               px_in  = req_x;
               py_in  = req_y;
               eos_in = req_tlast;
               if (open_ff) begin
                  dist_start = 1'b1;
                  state_in   = S_TEST;
               end else begin
                  state_in = S_OPEN;
               end
            end
         end
         S_TEST: begin
            if (!dist_busy) begin
               if (CMP_BITS'(d2) < CMP_BITS'(thr_ff)) begin
                  state_in = S_JOIN;
               end else begin
                  brk_in   = 1'b1;
                  state_in = S_CLOSE;
               end
            end
         end
         S_JOIN: begin
            // past the count limit the cluster still grows but sums hold
            if (count_ff < CNT_BITS'(COUNT_LIMIT)) begin
               sum_x_in = sum_x_ff + SUM_BITS'(px_ff);
               sum_y_in = sum_y_ff + SUM_BITS'(py_ff);
               count_in = count_ff + 1'b1;
            end
            prev_x_in = px_ff;
            prev_y_in = py_ff;
            brk_in    = 1'b0;
            state_in  = eos_ff ? S_CLOSE : S_IDLE;
         end
         S_OPEN: begin
            open_in    = 1'b1;
            first_x_in = px_ff;
            first_y_in = py_ff;
            prev_x_in  = px_ff;
            prev_y_in  = py_ff;
            sum_x_in   = SUM_BITS'(px_ff);
            sum_y_in   = SUM_BITS'(py_ff);
            count_in   = CNT_BITS'(1);
            brk_in     = 1'b0;
            state_in   = eos_ff ? S_CLOSE : S_IDLE;
         end
         S_CLOSE: begin
            open_in = 1'b0;
            if (qualify) begin
               dist_start = 1'b1;
               state_in   = S_RDIST;
            end else begin
               state_in = brk_ff ? S_OPEN : S_IDLE;
            end
         end
         S_RDIST: begin
            if (!dist_busy) begin
               calc_start = 1'b1;
               state_in   = S_CALC;
            end
         end
         S_CALC: begin
            if (!div_busy && !sqrt_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_cx_in    = quo_x;
               rsp_cy_in    = quo_y;
               rsp_rad_in   = (40'(half) > 40'd65535) ? '1 : RADIUS_BITS'(half);
               rsp_cnt_in   = POINTS_BITS'(count_ff);
               rsp_last_in  = brk_ff ? !eos_reports : 1'b1;
               state_in     = brk_ff ? S_OPEN : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         count_ff     <= '0;
         brk_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         count_ff     <= count_in;
         brk_ff       <= brk_in;
      end
      px_ff       <= px_in;
      py_ff       <= py_in;
      eos_ff      <= eos_in;
      rsp_cx_ff   <= rsp_cx_in;
      rsp_cy_ff   <= rsp_cy_in;
      rsp_rad_ff  <= rsp_rad_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = OUT_W'({rsp_cnt_ff, rsp_rad_ff, rsp_cy_ff, rsp_cx_ff});

endmodule

@@ hdl/spc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_checker: port-level checks for scan point clustering
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module spc_checker #(
   parameter int COORD_BITS = spc_pkg::SPC_COORD_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [((2*COORD_BITS+28+7)/8)*8-1:0] rsp_tdata,
   input  logic                                 rsp_tlast
);
   import spc_pkg::*;

   localparam int COUNT_LSB = 2 * COORD_BITS + RADIUS_BITS;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a reported cluster always holds at least one point
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[COUNT_LSB +: POINTS_BITS] != '0)
      else $error("empty cluster reported");

endmodule

bind scan_point_clustering spc_checker #(
   .COORD_BITS (COORD_BITS)
) u_spc_checker (.*);

@@ bench/cluster_report_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_report_checker: predictor and scoreboard for scan point clustering
// Watches the point, register and report channels. Each accepted point
// updates a local copy of the cluster state and queues the reports it must
// cause. Each accepted report is compared field by field with the oldest
// queued one. Hands the mismatch count and the number of outstanding reports
// to the bench top.
// ----------------------------------------------------------------------------
module cluster_report_checker #(
   parameter int COORD_W = spc_pkg::SPC_COORD_BITS,
   parameter int REQ_W   = ((2*spc_pkg::SPC_COORD_BITS+7)/8)*8,
   parameter int RSP_W   = ((2*spc_pkg::SPC_COORD_BITS+28+7)/8)*8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [REQ_W-1:0]                   req_tdata,
   input  logic                               req_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [RSP_W-1:0]                   rsp_tdata,
   input  logic                               rsp_tlast,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [spc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [spc_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                 mismatches,
   output int                                 pending
);
   import spc_pkg::*;

   localparam int RAD_LO = 2*COORD_W;
   localparam int CNT_LO = RAD_LO + RADIUS_BITS;
   localparam int PAD_LO = CNT_LO + POINTS_BITS;

   typedef struct packed {
      logic [COORD_W-1:0]     centre_x;
      logic [COORD_W-1:0]     centre_y;
      logic [RADIUS_BITS-1:0] radius;
      logic [POINTS_BITS-1:0] count;
      logic                   last;
   } cluster_report_type;

   // cluster state and register copies
   logic [15:0]            break_mm;
   logic [POINTS_BITS-1:0] min_pts;
   logic [POINTS_BITS-1:0] max_pts;
   bit                     cl_open;
   longint                 prev_x, prev_y, first_x, first_y, sum_x, sum_y;
   int unsigned            cl_points;

   cluster_report_type expected_reports[$];
   cluster_report_type want;
   int                 fail_total;

   function automatic longint unsigned span_sq(input longint ax, input longint ay,
                                               input longint bx, input longint by);
      longint unsigned dx, dy;
      dx = (ax >= bx) ? longint'(ax - bx) : longint'(bx - ax);
      dy = (ay >= by) ? longint'(ay - by) : longint'(by - ay);
      return dx * dx + dy * dy;
   endfunction

   function automatic void start_cluster(input longint px, input longint py);
      cl_open   = 1'b1;
      first_x   = px;
      first_y   = py;
      prev_x    = px;
      prev_y    = py;
      sum_x     = px;
      sum_y     = py;
      cl_points = 1;
   endfunction

   function automatic bit close_cluster(output cluster_report_type rep);
      longint unsigned rem, root, bitv;
      rep     = '0;
      cl_open = 1'b0;
      if (!(cl_points > min_pts && cl_points < max_pts)) begin
         return 1'b0;
      end
      // bitwise integer square root of the squared first-to-last span
      rem  = span_sq(first_x, first_y, prev_x, prev_y);
      root = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > rem) begin
         bitv = bitv >> 2;
      end
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      root = root >> 1;
      if (root > 65535) begin
         root = 65535;
      end
      rep.centre_x = COORD_W'(sum_x / longint'(cl_points));
      rep.centre_y = COORD_W'(sum_y / longint'(cl_points));
      rep.radius   = RADIUS_BITS'(root);
      rep.count    = POINTS_BITS'(cl_points);
      rep.last     = 1'b0;
      return 1'b1;
   endfunction

   task automatic predict_point(input longint px, input longint py, input bit eos);
      cluster_report_type found[2];
      cluster_report_type rep;
      int                 n_found;
      longint unsigned    limit_sq;
      n_found  = 0;
      limit_sq = longint'(break_mm) * longint'(break_mm);
      if (cl_open) begin
         if (span_sq(px, py, prev_x, prev_y) < limit_sq) begin
            // past the count limit, extend the cluster but freeze the sums
            if (cl_points < SPC_COUNT_LIMIT) begin
               sum_x     = sum_x + px;
               sum_y     = sum_y + py;
               cl_points = cl_points + 1;
            end
            prev_x = px;
            prev_y = py;
         end else begin
            if (close_cluster(rep)) begin
               found[n_found] = rep;
               n_found++;
            end
            start_cluster(px, py);
         end
      end else begin
         start_cluster(px, py);
      end
      if (eos && close_cluster(rep)) begin
         found[n_found] = rep;
         n_found++;
      end
      for (int i = 0; i < n_found; i++) begin
         if (i == n_found - 1) begin
            found[i].last = 1'b1;
         end
         expected_reports.insert(expected_reports.size(), found[i]);
      end
   endtask

   function automatic int check_field(input string name, input longint unsigned exp_v,
                                      input longint unsigned got_v);
      if (exp_v != got_v) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name,
                  exp_v, got_v);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         break_mm   = BREAK_RESET;
         min_pts    = MIN_POINTS_RESET;
         max_pts    = MAX_POINTS_RESET;
         cl_open    = 1'b0;
         prev_x     = 0;
         prev_y     = 0;
         first_x    = 0;
         first_y    = 0;
         sum_x      = 0;
         sum_y      = 0;
         cl_points  = 0;
         fail_total = 0;
         expected_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_BREAK: begin
                  break_mm = csr_data;
               end
               REG_MIN_POINTS: begin
                  min_pts = csr_data[POINTS_BITS-1:0];
               end
               REG_MAX_POINTS: begin
                  max_pts = csr_data[POINTS_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         // results leaving now were caused by earlier requests: check first
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t ns: unexpected report, expected none, actual %0h last %0b",
                        $time, rsp_tdata, rsp_tlast);
               fail_total++;
            end else begin
               want = expected_reports.pop_front();
               fail_total += check_field("centre_x", want.centre_x,
                                         rsp_tdata[COORD_W-1:0]);
               fail_total += check_field("centre_y", want.centre_y,
                                         rsp_tdata[RAD_LO-1:COORD_W]);
               fail_total += check_field("radius_mm", want.radius,
                                         rsp_tdata[CNT_LO-1:RAD_LO]);
               fail_total += check_field("point_count", want.count,
                                         rsp_tdata[PAD_LO-1:CNT_LO]);
               fail_total += check_field("last_in_run", want.last, rsp_tlast);
               fail_total += check_field("padding", 0, rsp_tdata[RSP_W-1:PAD_LO]);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_point(longint'($signed(req_tdata[COORD_W-1:0])),
                          longint'($signed(req_tdata[2*COORD_W-1:COORD_W])),
                          req_tlast);
         end
      end
      mismatches <= fail_total;
      pending    <= expected_reports.size();
   end

endmodule

@@ bench/scan_point_clustering_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_point_clustering_tb: stimulus and verdict for scan point clustering
// Drives directed corner points and random scan walks under several register
// settings and idle patterns, including a long output stall. Checking is done
// by the report checker.
// ----------------------------------------------------------------------------
module scan_point_clustering_tb;
   import spc_pkg::*;

   localparam int COORD_W   = SPC_COORD_BITS;
   localparam int REQ_W     = ((2*COORD_W+7)/8)*8;
   localparam int RSP_W     = ((2*COORD_W+28+7)/8)*8;
   localparam int COORD_MAX = 2**(COORD_W-1) - 1;
   localparam int COORD_MIN = -(2**(COORD_W-1));
   localparam int COORD_SPAN = 2**COORD_W - 1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

   localparam int SETTLE_CYCLES = 150;
   localparam int HOLD_CYCLES   = 600;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata;
   logic                      req_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_W-1:0]          rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   int mismatches;
   int pending;
   int sender_idle_pct;
   int rsp_idle_pct;
   bit hold_request;
   int cur_break;
   int cur_min;
   int cur_max;

   scan_point_clustering dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   cluster_report_checker report_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // receiver: random stalls, or one long hold when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready   <= 1'b0;
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic int clamp_coord(input int v);
      if (v > COORD_MAX) begin
         return COORD_MAX;
      end
      if (v < COORD_MIN) begin
         return COORD_MIN;
      end
      return v;
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(COORD_SPAN)) + COORD_MIN;
   endfunction

   function automatic int jitter(input int step);
      return int'($urandom_range(2 * step)) - step;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_point(input int px, input int py, input bit eos);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {COORD_W'(py), COORD_W'(px)};
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // a walk of len points, each within step of the previous one on each axis
   task automatic send_walk(input int len, input int x0, input int y0, input int step,
                            input bit eos_end);
      int px, py;
      px = x0;
      py = y0;
      for (int i = 0; i < len; i++) begin
         if (i > 0) begin
            px = clamp_coord(px + jitter(step));
            py = clamp_coord(py + jitter(step));
         end
         send_point(px, py, eos_end && (i == len - 1));
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // upper bits of the count registers carry junk that must be dropped
   task automatic configure(input int brk, input int min_v, input int max_v,
                            input bit poke_unused);
      write_reg(REG_BREAK, CSR_DATA_BITS'(brk));
      write_reg(REG_MIN_POINTS, {4'($urandom), POINTS_BITS'(min_v)});
      write_reg(REG_MAX_POINTS, {4'($urandom), POINTS_BITS'(max_v)});
      if (poke_unused) begin
         write_reg(REG_UNUSED, CSR_DATA_BITS'($urandom));
      end
      csr_valid <= 1'b0;
      cur_break = brk;
      cur_min   = min_v;
      cur_max   = max_v;
   endtask

   // stop sending, let every report arrive, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_segment(input int n_items);
      int sent, len, step, px, py;
      sent = 0;
      step = (cur_break * 7) / 10;
      while (sent < n_items) begin
         case ($urandom_range(19))
            0, 1: begin
               send_point(any_coord(), any_coord(), $urandom_range(7) == 0);
               sent++;
            end
            2: begin
               // step of exactly the break distance: must break
               px = int'($urandom_range(COORD_SPAN - cur_break)) + COORD_MIN;
               py = any_coord();
               send_point(px, py, 1'b0);
               send_point(px + cur_break, py, $urandom_range(1));
               sent += 2;
            end
            default: begin
               case ($urandom_range(3))
                  0: len = $urandom_range(1, 3);
                  1: len = cur_min + $urandom_range(3);
                  2: len = (cur_max > 2) ? cur_max - int'($urandom_range(2)) : 1;
                  default: len = $urandom_range(1, 12);
               endcase
               if (len > 40) begin
                  len = 40;
               end
               if (len < 1) begin
                  len = 1;
               end
               send_walk(len, any_coord(), any_coord(), step, $urandom_range(3) == 0);
               sent += len;
            end
         endcase
      end
      drain();
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tlast       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = REG_BREAK;
      csr_data        = '0;
      hold_request    = 1'b0;
      sender_idle_pct = 16;
      rsp_idle_pct    = 64;
      cur_break       = 100;
      cur_min         = 2;
      cur_max         = 100;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: coordinate extremes, break exactly at 100
      send_point(COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MIN + 50, COORD_MIN, 1'b0);
      send_point(COORD_MIN + 50, COORD_MIN + 99, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 1'b0);
      send_point(COORD_MAX - 60, COORD_MAX - 60, 1'b0);
      send_point(COORD_MAX - 120, COORD_MAX - 120, 1'b0);
      send_point(COORD_MAX - 120, COORD_MAX - 20, 1'b1);
      send_point(0, 0, 1'b0);
      send_point(99, 0, 1'b0);
      send_point(99, 99, 1'b1);
      drain();

      // zero break distance: single point clusters, two reports on one point
      configure(0, 0, 4095, 1'b1);
      send_point(5, 5, 1'b0);
      send_point(5, 5, 1'b0);
      send_point(-1, -1, 1'b1);
      drain();

      // widest break: only the largest spans break
      configure(65535, 0, 4095, 1'b0);
      send_point(COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 1'b0);
      send_point(COORD_MAX, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MIN + 1, 1'b0);
      send_point(0, 0, 1'b1);
      drain();

      // nothing can qualify
      configure(100, 4095, 0, 1'b0);
      send_point(1, 1, 1'b0);
      send_point(2, 2, 1'b1);
      drain();

      configure(100, 2, 100, 1'b0);
      run_segment(110);
      configure(3000, 0, 5, 1'b1);
      run_segment(110);

      sender_idle_pct = 64;
      rsp_idle_pct    = 16;
      configure(1, 1, 4, 1'b0);
      run_segment(110);
      configure(65535, 4095, 4095, 1'b0);
      run_segment(60);
      configure(500, 3, 12, 1'b0);
      run_segment(110);

      sender_idle_pct = 0;
      rsp_idle_pct    = 0;
      configure(20000, 0, 4095, 1'b0);
      hold_request = 1'b1;
      run_segment(150);

      if (mismatches == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
